// File: rtl/core/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

    // Table geometry
    localparam int NPC_MAX_ENTRIES = 64;
    localparam int NPC_ADDR_W      = $clog2(NPC_MAX_ENTRIES);
    localparam int NPC_COUNT_W     = 8;
    localparam int NPC_ID_W        = 8;

    // Command queue between front and back
    localparam int NPC_QUEUE_DEPTH = 2;
    localparam int NPC_QPTR_W      = $clog2(NPC_QUEUE_DEPTH);
    localparam int NPC_QCNT_W      = $clog2(NPC_QUEUE_DEPTH + 1);

    // Datapath widths, Q.12 integers; squares and distances Q.24
    localparam int NPC_OFS_W    = 17;  // noise + 1.0
    localparam int NPC_SCALED_W = 22;  // (noise + 1.0) * 50
    localparam int NPC_POINT_W  = 24;  // Q12.4 point widened to Q.12
    localparam int NPC_DIFF_W   = 25;
    localparam int NPC_SQ_W     = 47;
    localparam int NPC_DIST_W   = 48;

    localparam logic signed [NPC_OFS_W-1:0] NPC_NOISE_ONE = 17'sd4096;

    typedef enum logic [0:0] {
        MODE_ADD      = 1'b0,
        MODE_CLASSIFY = 1'b1
    } t_npc_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LOCKED = 2'd1,
        ST_FULL   = 2'd2
    } t_npc_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_npc_state;

    typedef struct packed {
        t_npc_mode          mode;
        logic signed [15:0] noise_heat;
        logic signed [15:0] noise_humidity;
        logic signed [15:0] height;
        logic signed [15:0] point_heat;
        logic signed [15:0] point_humidity;
        logic signed [15:0] height_low;
        logic signed [15:0] height_high;
    } t_npc_in;

    typedef struct packed {
        logic [NPC_ID_W-1:0] class_id;
        t_npc_status         status;
    } t_npc_out;

    // Stored entry, high word first
    typedef struct packed {
        logic signed [15:0] high;
        logic signed [15:0] low;
        logic signed [15:0] humidity;
        logic signed [15:0] heat;
    } t_npc_entry;

    typedef struct packed {
        t_npc_mode                      mode;
        logic signed [NPC_SCALED_W-1:0] heat;
        logic signed [NPC_SCALED_W-1:0] humidity;
        logic signed [15:0]             height;
        t_npc_entry                     entry;
    } t_npc_cmd;

endpackage

// File: rtl/core/npc_front.sv
`timescale 1ns / 1ps

module npc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  npc_pkg::t_npc_in   i_item,
    output logic               o_full,
    output logic               o_cmd_vld,
    output npc_pkg::t_npc_cmd  o_cmd,
    input  logic               i_cmd_pop
);

    npc_pkg::t_npc_cmd                    r_q [npc_pkg::NPC_QUEUE_DEPTH];
    logic [npc_pkg::NPC_QPTR_W-1:0]       r_wp;
    logic [npc_pkg::NPC_QPTR_W-1:0]       r_rp;
    logic [npc_pkg::NPC_QCNT_W-1:0]       r_cnt;
    logic [npc_pkg::NPC_QPTR_W-1:0]       n_wp;
    logic [npc_pkg::NPC_QPTR_W-1:0]       n_rp;
    logic [npc_pkg::NPC_QCNT_W-1:0]       n_cnt;

    logic signed [npc_pkg::NPC_OFS_W-1:0]    heat_ofs;
    logic signed [npc_pkg::NPC_OFS_W-1:0]    hum_ofs;
    logic signed [npc_pkg::NPC_SCALED_W-1:0] heat_x;
    logic signed [npc_pkg::NPC_SCALED_W-1:0] hum_x;
    npc_pkg::t_npc_cmd                       cmd;

    // Scale noise: (n + 1.0) * 50 as shift-add (32 + 16 + 2)
    always_comb begin
        heat_ofs = npc_pkg::NPC_OFS_W'(i_item.noise_heat) + npc_pkg::NPC_NOISE_ONE;
        hum_ofs  = npc_pkg::NPC_OFS_W'(i_item.noise_humidity) + npc_pkg::NPC_NOISE_ONE;
        heat_x   = npc_pkg::NPC_SCALED_W'(heat_ofs);
        hum_x    = npc_pkg::NPC_SCALED_W'(hum_ofs);
        cmd.mode           = i_item.mode;
        cmd.heat           = (heat_x <<< 5) + (heat_x <<< 4) + (heat_x <<< 1);
        cmd.humidity       = (hum_x <<< 5) + (hum_x <<< 4) + (hum_x <<< 1);
        cmd.height         = i_item.height;
        cmd.entry.heat     = i_item.point_heat;
        cmd.entry.humidity = i_item.point_humidity;
        cmd.entry.low      = i_item.height_low;
        cmd.entry.high     = i_item.height_high;
    end

    assign o_full    = (r_cnt == npc_pkg::NPC_QCNT_W'(npc_pkg::NPC_QUEUE_DEPTH));
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == npc_pkg::NPC_QPTR_W'(npc_pkg::NPC_QUEUE_DEPTH - 1))
                 ? '0 : r_wp + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rp = (r_rp == npc_pkg::NPC_QPTR_W'(npc_pkg::NPC_QUEUE_DEPTH - 1))
                 ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// File: rtl/core/npc_back.sv
`timescale 1ns / 1ps

module npc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_cmd_vld,
    input  npc_pkg::t_npc_cmd  i_cmd,
    output logic               o_cmd_pop,
    output logic               o_done,
    output npc_pkg::t_npc_out  o_result
);

    npc_pkg::t_npc_state                     r_state;
    npc_pkg::t_npc_state                     n_state;
    logic                                    r_locked;
    logic [npc_pkg::NPC_COUNT_W-1:0]         r_count;
    logic [npc_pkg::NPC_COUNT_W-1:0]         r_idx;

    npc_pkg::t_npc_entry                     r_table [npc_pkg::NPC_MAX_ENTRIES];

    logic signed [npc_pkg::NPC_SCALED_W-1:0] r_heat;
    logic signed [npc_pkg::NPC_SCALED_W-1:0] r_hum;
    logic signed [15:0]                      r_height;

    // Scan pipeline: read, window/diff, square, compare
    logic                                    r_rd_vld;
    logic [npc_pkg::NPC_ID_W-1:0]            r_rd_idx;
    npc_pkg::t_npc_entry                     r_rd_data;
    logic                                    r_s2_vld;
    logic [npc_pkg::NPC_ID_W-1:0]            r_s2_idx;
    logic signed [npc_pkg::NPC_DIFF_W-1:0]   r_s2_dh;
    logic signed [npc_pkg::NPC_DIFF_W-1:0]   r_s2_du;
    logic                                    r_s3_vld;
    logic [npc_pkg::NPC_ID_W-1:0]            r_s3_idx;
    logic [npc_pkg::NPC_SQ_W-1:0]            r_s3_sqh;
    logic [npc_pkg::NPC_SQ_W-1:0]            r_s3_squ;
    logic                                    r_found;
    logic [npc_pkg::NPC_DIST_W-1:0]          r_best;
    logic [npc_pkg::NPC_ID_W-1:0]            r_best_id;

    logic                                    r_done;
    npc_pkg::t_npc_out                       r_result;

    logic                                    issue;
    logic                                    emit;
    logic                                    pipe_empty;
    logic                                    add_do;
    logic                                    add_ok;
    npc_pkg::t_npc_status                    add_status;
    logic                                    qual;
    logic signed [npc_pkg::NPC_POINT_W-1:0]  ph;
    logic signed [npc_pkg::NPC_POINT_W-1:0]  pu;
    logic signed [npc_pkg::NPC_DIFF_W-1:0]   dh;
    logic signed [npc_pkg::NPC_DIFF_W-1:0]   du;
    logic signed [2*npc_pkg::NPC_DIFF_W-1:0] prod_h;
    logic signed [2*npc_pkg::NPC_DIFF_W-1:0] prod_u;
    logic [npc_pkg::NPC_DIST_W-1:0]          sq_dist;
    logic                                    upd;

    assign pipe_empty = !r_rd_vld && !r_s2_vld && !r_s3_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npc_pkg::S_IDLE: begin
                if (i_cmd_vld && i_cmd.mode == npc_pkg::MODE_CLASSIFY) begin
                    n_state = npc_pkg::S_SCAN;
                end
            end
            npc_pkg::S_SCAN: begin
                if (r_idx >= r_count) begin
                    n_state = npc_pkg::S_FLUSH;
                end
            end
            npc_pkg::S_FLUSH: begin
                if (pipe_empty) begin
                    n_state = npc_pkg::S_IDLE;
                end
            end
            default: n_state = npc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            npc_pkg::S_IDLE:  o_cmd_pop = i_cmd_vld;
            npc_pkg::S_SCAN:  issue     = (r_idx < r_count);
            npc_pkg::S_FLUSH: emit      = pipe_empty;
            default: ;
        endcase
    end

    // Add: lock wins over full
    always_comb begin
        add_do = o_cmd_pop && i_cmd.mode == npc_pkg::MODE_ADD;
        priority if (r_locked) begin
            add_status = npc_pkg::ST_LOCKED;
        end else if (r_count >= npc_pkg::NPC_COUNT_W'(npc_pkg::NPC_MAX_ENTRIES)) begin
            add_status = npc_pkg::ST_FULL;
        end else begin
            add_status = npc_pkg::ST_OK;
        end
        add_ok = add_do && add_status == npc_pkg::ST_OK;
    end

    // Window test, Q.12 differences, squares and best-distance compare
    always_comb begin
        qual    = (r_height >= r_rd_data.low) && (r_height <= r_rd_data.high);
        ph      = {r_rd_data.heat, 8'h00};
        pu      = {r_rd_data.humidity, 8'h00};
        dh      = npc_pkg::NPC_DIFF_W'(r_heat) - npc_pkg::NPC_DIFF_W'(ph);
        du      = npc_pkg::NPC_DIFF_W'(r_hum) - npc_pkg::NPC_DIFF_W'(pu);
        prod_h  = r_s2_dh * r_s2_dh;
        prod_u  = r_s2_du * r_s2_du;
        sq_dist = npc_pkg::NPC_DIST_W'(r_s3_sqh) + npc_pkg::NPC_DIST_W'(r_s3_squ);
        // Strict less-than keeps the lowest id on a tie
        upd     = r_s3_vld && (!r_found || sq_dist < r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= npc_pkg::S_IDLE;
            r_locked <= 1'b0;
            r_count  <= npc_pkg::NPC_COUNT_W'(1);
            r_idx    <= npc_pkg::NPC_COUNT_W'(1);
            r_rd_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_locked <= i_cfg_wdata;
            end
            if (add_ok) begin
                r_count <= r_count + 1'b1;
            end
            if (o_cmd_pop) begin
                r_idx <= npc_pkg::NPC_COUNT_W'(1);
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rd_vld <= issue;
            r_s2_vld <= r_rd_vld && qual;
            r_s3_vld <= r_s2_vld;
            if (o_cmd_pop) begin
                r_found <= 1'b0;
            end else if (upd) begin
                r_found <= 1'b1;
            end
            r_done <= add_do || emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_ok) begin
            r_table[r_count[npc_pkg::NPC_ADDR_W-1:0]] <= i_cmd.entry;
        end
        if (issue) begin
            r_rd_data <= r_table[r_idx[npc_pkg::NPC_ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_heat   <= i_cmd.heat;
            r_hum    <= i_cmd.humidity;
            r_height <= i_cmd.height;
        end
        r_rd_idx <= r_idx;
        r_s2_idx <= r_rd_idx;
        r_s2_dh  <= dh;
        r_s2_du  <= du;
        r_s3_idx <= r_s2_idx;
        r_s3_sqh <= prod_h[npc_pkg::NPC_SQ_W-1:0];
        r_s3_squ <= prod_u[npc_pkg::NPC_SQ_W-1:0];
        if (o_cmd_pop) begin
            r_best_id <= '0;
        end else if (upd) begin
            r_best    <= sq_dist;
            r_best_id <= r_s3_idx;
        end
        if (add_do) begin
            r_result.class_id <= add_ok ? r_count : '0;
            r_result.status   <= add_status;
        end else if (emit) begin
            r_result.class_id <= r_best_id;
            r_result.status   <= npc_pkg::ST_OK;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= npc_pkg::NPC_COUNT_W'(npc_pkg::NPC_MAX_ENTRIES))
        else $error("entry count out of range");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best_id != '0 && r_best_id < r_count))
        else $error("best id outside stored entries");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == npc_pkg::S_IDLE)
        else $error("result strobe while a scan is open");

    a_flush_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == npc_pkg::S_FLUSH |=> !r_rd_vld)
        else $error("table read issued during flush");
`endif

endmodule

// File: rtl/core/nearest_point_classifier_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when           Payload
// item      in         start & !busy           i_item   (npc_pkg::t_npc_in)
// result    out        o_done (one cycle)      o_result (npc_pkg::t_npc_out)
// config    in         i_cfg_we                i_cfg_wdata (table lock)
//
// An add result is registered once the back pops the command from the
// queue; a classify result follows a scan that reads one table entry
// per cycle from the single-port entry memory. busy rises when the
// two-deep command queue is full; items queue while a scan runs. Reset
// (synchronous, active low) clears the lock, the queue and sets the
// entry count to 1. The receiver cannot stall results.
module nearest_point_classifier_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  npc_pkg::t_npc_in   i_item,
    output logic               o_done,
    output npc_pkg::t_npc_out  o_result,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    logic              cmd_vld;
    logic              cmd_pop;
    logic              q_full;
    npc_pkg::t_npc_cmd cmd;

    // Front: take items, scale noise, hold them in the queue
    npc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (start && !q_full),
        .i_item    (i_item),
        .o_full    (q_full),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    // Back: append entries or scan the table for the nearest point
    npc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_vld   (cmd_vld),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    assign busy = q_full;

endmodule
